// ----- rtl/core/stxdec_pkg.sv -----
// ----------------------------------------------------------------------------
// STX/ETX frame decoder package
// Shared character codes, state and result kinds, and the structs that pass
// words and results between the stages of the decoder.
// ----------------------------------------------------------------------------
package stxdec_pkg;

  // Line control characters.
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_DLE = 8'h10;

  // Reset value of the payload length limit.
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  // Field widths of the result channel.
  localparam int KIND_W   = 3;
  localparam int DATA_W   = 8;
  localparam int FLEN_W   = 16;
  localparam int FCOUNT_W = 32;

  // Receive phase of the deframer.
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_BODY    = 2'd1,
    PH_LITERAL = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  // Kind of a result word.
  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD      = 3'd2,
    KIND_RESTART  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  // A received line byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } word_t;

  // One result word together with its valid flag.
  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [DATA_W-1:0]   data;
    logic [FLEN_W-1:0]   frame_length;
    logic [FCOUNT_W-1:0] good_frames;
    logic [FCOUNT_W-1:0] error_frames;
  } result_t;

endpackage

// ----- rtl/core/stxdec_in_reg.sv -----
// ----------------------------------------------------------------------------
// STX/ETX frame decoder input register
// Captures one line byte per cycle and holds it while the result side stalls.
// ----------------------------------------------------------------------------
module stxdec_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_rx_byte,
  input  logic                ready,
  output logic                in_stall,
  output stxdec_pkg::word_t   word
);
  import stxdec_pkg::*;

  word_t word_r;

  // The held word can only stay put when the decoder cannot take it.
  assign in_stall = word_r.valid && !ready;
  assign word     = word_r;

  // Load a new word whenever the register is free or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (!in_stall) begin
      word_r.valid <= in_valid;
      if (in_valid) begin
        word_r.rx_byte <= in_rx_byte;
      end
    end
  end

endmodule

// ----- rtl/core/stxdec_core.sv -----
// ----------------------------------------------------------------------------
// STX/ETX frame decoder core
// Phase machine, running checksum, payload counter and frame counters. Works
// out the result of one byte combinationally.
// ----------------------------------------------------------------------------
module stxdec_core #(
  parameter int LENGTH_BITS  = 16,
  parameter int COUNTER_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  stxdec_pkg::word_t     word,
  input  logic [15:0]           max_payload,
  output stxdec_pkg::result_t   result
);
  import stxdec_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > FLEN_W) ? LENGTH_BITS : FLEN_W;
  localparam int CNT_W = (COUNTER_BITS > FCOUNT_W) ? COUNTER_BITS : FCOUNT_W;

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              sum_r, sum_nxt;
  logic [LENGTH_BITS-1:0]  count_r, count_nxt;
  logic [COUNTER_BITS-1:0] good_r, good_nxt;
  logic [COUNTER_BITS-1:0] err_r, err_nxt;

  logic                    is_stx, is_etx, is_dle;
  logic                    payload, overflow;
  logic                    res_valid;
  kind_t                   res_kind;
  logic [7:0]              res_data;
  logic [LENGTH_BITS-1:0]  len;
  logic [CMP_W-1:0]        len_ext;
  logic [CNT_W-1:0]        good_ext, err_ext;

  assign is_stx = (word.rx_byte == CH_STX);
  assign is_etx = (word.rx_byte == CH_ETX);
  assign is_dle = (word.rx_byte == CH_DLE);

  // A byte is payload when escaped, or in the body and not a control code.
  assign payload = (phase_r == PH_LITERAL) ||
                   ((phase_r == PH_BODY) && !is_stx && !is_etx && !is_dle);

  // The frame is dropped at the configured limit or when the counter is full.
  assign overflow = (CMP_W'(count_r) >= CMP_W'(max_payload)) || (count_r == '1);

  // Next phase.
  always_comb begin
    case (phase_r)
      PH_HUNT: begin
        phase_nxt = is_stx ? PH_BODY : PH_HUNT;
      end
      PH_BODY: begin
        if (is_stx) begin
          phase_nxt = PH_BODY;
        end else if (is_etx) begin
          phase_nxt = PH_CHECK;
        end else if (is_dle) begin
          phase_nxt = PH_LITERAL;
        end else begin
          phase_nxt = overflow ? PH_HUNT : PH_BODY;
        end
      end
      PH_LITERAL: begin
        phase_nxt = overflow ? PH_HUNT : PH_BODY;
      end
      PH_CHECK: begin
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // Datapath updates and the result word.
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    good_nxt  = good_r;
    err_nxt   = err_r;
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_data  = '0;
    len       = count_r;
    case (phase_r)
      PH_HUNT: begin
        if (is_stx) begin
          sum_nxt   = '0;
          count_nxt = '0;
        end
      end
      PH_BODY: begin
        // A fresh STX abandons the frame and opens a new one.
        if (is_stx) begin
          sum_nxt   = '0;
          count_nxt = '0;
          err_nxt   = err_r + 1'b1;
          res_valid = 1'b1;
          res_kind  = KIND_RESTART;
        end
      end
      PH_CHECK: begin
        count_nxt = '0;
        res_valid = 1'b1;
        if (sum_r == word.rx_byte) begin
          good_nxt = good_r + 1'b1;
          res_kind = KIND_GOOD;
        end else begin
          err_nxt  = err_r + 1'b1;
          res_kind = KIND_BAD;
        end
      end
      default: begin
      end
    endcase

    // Payload bytes are either passed on or drop the frame.
    if (payload) begin
      res_valid = 1'b1;
      if (overflow) begin
        count_nxt = '0;
        res_kind  = KIND_OVERFLOW;
      end else begin
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_r + word.rx_byte;
        res_kind  = KIND_PAYLOAD;
        res_data  = word.rx_byte;
        len       = count_r + 1'b1;
      end
    end
  end

  // Fit lengths and counters to the result field widths.
  assign len_ext  = CMP_W'(len);
  assign good_ext = CNT_W'(good_nxt);
  assign err_ext  = CNT_W'(err_nxt);

  assign result.valid        = res_valid;
  assign result.kind         = res_kind;
  assign result.data         = res_data;
  assign result.frame_length = len_ext[FLEN_W-1:0];
  assign result.good_frames  = good_ext[FCOUNT_W-1:0];
  assign result.error_frames = err_ext[FCOUNT_W-1:0];

  // State registers advance once per word taken from the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= '0;
      count_r <= '0;
      good_r  <= '0;
      err_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      good_r  <= good_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- rtl/core/stxdec_out_reg.sv -----
// ----------------------------------------------------------------------------
// STX/ETX frame decoder result register
// Holds one result word until the receiver takes it and tells the decoder
// when a new result may be written.
// ----------------------------------------------------------------------------
module stxdec_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  stxdec_pkg::result_t   result,
  input  logic                  out_stall,
  output logic                  ready,
  output stxdec_pkg::result_t   held
);
  import stxdec_pkg::*;

  result_t held_r;

  // Free when empty or when the held word leaves this cycle.
  assign ready = !held_r.valid || !out_stall;
  assign held  = held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (load) begin
      held_r <= result;
    end else if (!out_stall) begin
      held_r.valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/stx_etx_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// STX/ETX frame decoder
// Deframes a DLE-stuffed STX/ETX byte stream with an 8-bit additive checksum
// and reports payload bytes, frame ends and running frame counts.
//
//   Channel   Direction  Handshake             Contents
//   in_       input      in_valid / in_stall   one raw line byte
//   out_      output     out_valid / out_stall kind, data, length, counts
//   cfg_      input      cfg_wr_en             payload length limit
//
// One word is taken every cycle unless a stalled result holds the input
// register; the phase machine and its adders settle combinationally
// between the input register and the result register. An accepted word
// has its result loaded into the result register once that is free.
// Reset returns the decoder to hunting for STX, clears the counters and sets
// the payload limit to 1024.
// A stalled result holds the input register; the input stalls only then.
// ----------------------------------------------------------------------------
module stx_etx_frame_decoder_top #(
  parameter int LENGTH_BITS  = 16,
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data,
  output logic [15:0] out_frame_length,
  output logic [31:0] out_good_frames,
  output logic [31:0] out_error_frames,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import stxdec_pkg::*;

  logic        ready;
  logic        step;
  word_t       word;
  result_t     result;
  result_t     held;
  logic [15:0] max_payload_r;

  // Payload length limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  // Input register.
  stxdec_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .ready      (ready),
    .in_stall   (in_stall),
    .word       (word)
  );

  assign step = word.valid && ready;

  // Deframing logic.
  stxdec_core #(
    .LENGTH_BITS  (LENGTH_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .word        (word),
    .max_payload (max_payload_r),
    .result      (result)
  );

  // Result register.
  stxdec_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .result    (result),
    .out_stall (out_stall),
    .ready     (ready),
    .held      (held)
  );

  assign out_valid        = held.valid;
  assign out_kind         = held.kind;
  assign out_data         = held.data;
  assign out_frame_length = held.frame_length;
  assign out_good_frames  = held.good_frames;
  assign out_error_frames = held.error_frames;

  // Only payload words carry a data byte.
  a_data_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_PAYLOAD) |-> (out_data == '0))
    else $error("non-payload result carries data");

  // A payload word always counts at least itself.
  a_len_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PAYLOAD) |-> (out_frame_length != '0))
    else $error("payload result with zero length");

  // The good-frame count only moves with a good-frame result.
  a_good_moves : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_good_frames != $past(out_good_frames))
      |-> (out_valid && out_kind == KIND_GOOD))
    else $error("good-frame count changed without a good frame");

  // The error count only moves with a bad-checksum or restart result.
  a_err_moves : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_error_frames != $past(out_error_frames))
      |-> (out_valid && (out_kind == KIND_BAD || out_kind == KIND_RESTART)))
    else $error("error count changed without an error result");

endmodule

// ----- tb/frame_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// STX/ETX frame decoder checker
// Watches the line, result and limit ports of the decoder, keeps its own
// copy of the deframing state, predicts the result word of every accepted
// line word and compares each accepted result word with the oldest one due.
// ----------------------------------------------------------------------------
module frame_decoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_data,
  input  logic [15:0] out_frame_length,
  input  logic [31:0] out_good_frames,
  input  logic [31:0] out_error_frames,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int unsigned pending_words,
  output int unsigned mismatch_count
);
  import stxdec_pkg::*;

  // One decoded event as the result channel should show it.
  typedef struct {
    kind_t        kind;
    logic [7:0]   data;
    logic [15:0]  frame_length;
    logic [31:0]  good_frames;
    logic [31:0]  error_frames;
  } frame_event_t;

  // Deframing state mirrored from the decoder.
  phase_t       rx_phase;
  logic [7:0]   rx_sum;
  logic [15:0]  rx_count;
  logic [31:0]  good_total;
  logic [31:0]  error_total;
  logic [15:0]  payload_limit;

  frame_event_t events_due[$];
  int unsigned  mismatches = 0;
  int unsigned  words_awaited = 0;

  assign pending_words  = words_awaited;
  assign mismatch_count = mismatches;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Queues an event with the counters as they stand after this word.
  task automatic queue_event(input kind_t kind, input logic [7:0] data,
                             input logic [15:0] flen);
    frame_event_t ev;
    ev.kind         = kind;
    ev.data         = data;
    ev.frame_length = flen;
    ev.good_frames  = good_total;
    ev.error_frames = error_total;
    events_due.push_back(ev);
  endtask

  // Advances the deframing state by one line byte.
  task automatic decode_byte(input logic [7:0] b);
    logic       is_payload;
    logic [7:0] sum_seen;
    is_payload = 1'b0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == CH_STX) begin
          rx_phase = PH_BODY;
          rx_sum   = 8'd0;
          rx_count = 16'd0;
        end
      end
      PH_CHECK: begin
        sum_seen = rx_sum;
        rx_phase = PH_HUNT;
        if (sum_seen == b) begin
          good_total = good_total + 32'd1;
          queue_event(KIND_GOOD, 8'd0, rx_count);
        end else begin
          error_total = error_total + 32'd1;
          queue_event(KIND_BAD, 8'd0, rx_count);
        end
        rx_count = 16'd0;
      end
      PH_LITERAL: begin
        rx_phase   = PH_BODY;
        is_payload = 1'b1;
      end
      default: begin
        if (b == CH_STX) begin
          // A fresh STX abandons the frame and starts another one.
          error_total = error_total + 32'd1;
          queue_event(KIND_RESTART, 8'd0, rx_count);
          rx_count = 16'd0;
          rx_sum   = 8'd0;
        end else if (b == CH_ETX) begin
          rx_phase = PH_CHECK;
        end else if (b == CH_DLE) begin
          rx_phase = PH_LITERAL;
        end else begin
          is_payload = 1'b1;
        end
      end
    endcase

    // Payload bytes either extend the frame or drop it at the length limit.
    if (is_payload) begin
      if (rx_count >= payload_limit || rx_count == 16'hFFFF) begin
        queue_event(KIND_OVERFLOW, 8'd0, rx_count);
        rx_phase = PH_HUNT;
        rx_count = 16'd0;
      end else begin
        rx_count = rx_count + 16'd1;
        rx_sum   = rx_sum + b;
        queue_event(KIND_PAYLOAD, b, rx_count);
      end
    end
  endtask

  // Compares an accepted result word with the oldest event due.
  task automatic check_result();
    frame_event_t ev;
    if (events_due.size() == 0) begin
      report_mismatch("unexpected result word, kind", 32'(out_kind), 32'd0);
    end else begin
      ev = events_due.pop_front();
      if (out_kind !== ev.kind)
        report_mismatch("kind", 32'(out_kind), 32'(ev.kind));
      if (out_data !== ev.data)
        report_mismatch("data", 32'(out_data), 32'(ev.data));
      if (out_frame_length !== ev.frame_length)
        report_mismatch("frame_length", 32'(out_frame_length), 32'(ev.frame_length));
      if (out_good_frames !== ev.good_frames)
        report_mismatch("good_frames", out_good_frames, ev.good_frames);
      if (out_error_frames !== ev.error_frames)
        report_mismatch("error_frames", out_error_frames, ev.error_frames);
    end
  endtask

  // Limit writes land first, then results drain, then new words are decoded.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase      = PH_HUNT;
      rx_sum        = 8'd0;
      rx_count      = 16'd0;
      good_total    = 32'd0;
      error_total   = 32'd0;
      payload_limit = MAX_PAYLOAD_RESET;
      events_due.delete();
    end else begin
      if (cfg_wr_en)
        payload_limit = cfg_wr_data;
      if (out_valid && !out_stall)
        check_result();
      if (in_valid && !in_stall)
        decode_byte(in_rx_byte);
    end
    words_awaited <= events_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// STX/ETX frame decoder testbench
// Drives byte-stuffed line traffic into the decoder in bursts under a varying
// result-side stall pattern, steps the payload limit through its extremes
// and several random settings, and leaves checking to the attached checker.
// ----------------------------------------------------------------------------
module testbench;
  import stxdec_pkg::*;

  localparam int          RESULT_LATENCY = 2;
  localparam int unsigned CYCLE_LIMIT    = 4000000;
  localparam int          PHASE_COUNT    = 8;
  localparam int          HALF_PHASE     = 70;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data;
  logic [15:0] out_frame_length;
  logic [31:0] out_good_frames;
  logic [31:0] out_error_frames;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int unsigned pending_words;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  logic [9:0]  stall_step;
  logic [7:0]  line_q[$];

  // Clock with a period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stx_etx_frame_decoder_top #(
    .LENGTH_BITS (16),
    .COUNTER_BITS(32)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_frame_length(out_frame_length),
    .out_good_frames (out_good_frames),
    .out_error_frames(out_error_frames),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  frame_decoder_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_frame_length(out_frame_length),
    .out_good_frames (out_good_frames),
    .out_error_frames(out_error_frames),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .pending_words   (pending_words),
    .mismatch_count  (mismatch_count)
  );

  // The result side cycles through free running, heavy, light and
  // regular stall patterns.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_step <= 10'd0;
      out_stall  <= 1'b0;
    end else begin
      stall_step <= stall_step + 10'd1;
      case (stall_step[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 1) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= (stall_step[2:0] < 3'd3);
      endcase
    end
  end

  // A stuck decoder ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Payload values lean towards the control characters and the extremes.
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return CH_STX;
      1: return CH_ETX;
      2: return CH_DLE;
      3: return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Control characters are always escaped; ordinary bytes now and then.
  function automatic void put_payload(input logic [7:0] b);
    if (b == CH_STX || b == CH_ETX || b == CH_DLE || $urandom_range(0, 9) == 0)
      line_q.push_back(CH_DLE);
    line_q.push_back(b);
  endfunction

  // A complete frame with a good or a corrupted checksum.
  function automatic void add_frame(input int len, input bit sum_ok);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'd0;
    line_q.push_back(CH_STX);
    for (int i = 0; i < len; i++) begin
      b   = pick_payload();
      sum = sum + b;
      put_payload(b);
    end
    line_q.push_back(CH_ETX);
    line_q.push_back(sum_ok ? sum : (sum ^ 8'($urandom_range(1, 255))));
  endfunction

  // Mostly well-formed frames sized around the limit, with abandoned
  // frames, line noise and unescaped bodies mixed in.
  function automatic void fill_traffic(input int words, input int unsigned limit);
    int unsigned cap;
    int unsigned len;
    int unsigned pick;
    cap = (limit < 24) ? limit : 24;
    while (line_q.size() < words) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap + 2) :
                                            $urandom_range(0, cap);
      if (pick < 72) begin
        add_frame(len, $urandom_range(0, 4) != 0);
      end else if (pick < 82) begin
        // No ETX: the next STX restarts this frame.
        line_q.push_back(CH_STX);
        repeat (len) put_payload(pick_payload());
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        line_q.push_back(CH_STX);
        repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
        line_q.push_back(CH_ETX);
      end
    end
  endfunction

  // Offers one line word, idling first when the current burst is spent.
  task automatic send_word(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                  $urandom_range(1, 16);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_word(line_q.pop_front());
  endtask

  // Holds the sender until every result due has arrived and the pipeline
  // has had time to settle words that give no result.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned limit;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 16'h0000;
    rst_n       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: noise while hunting, a DLE ignored before STX, a frame
    // carrying the extremes and every escaped control character with a
    // good checksum, then a restart by STX and a bad checksum.
    line_q = '{8'h00, 8'hFF, CH_ETX, CH_DLE,
               CH_STX, 8'h00, 8'hFF, CH_DLE, CH_STX, CH_DLE, CH_ETX,
               CH_DLE, CH_DLE, CH_ETX, 8'h14,
               CH_STX, 8'h41, CH_STX, 8'h42, CH_ETX, 8'h00};
    send_line();
    wait_for_results();

    // Random phases, each under its own payload limit and each drained
    // half way through.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: limit = 1;
        1: limit = 0;
        2: limit = 16'hFFFF;
        3: limit = $urandom_range(2, 8);
        4: limit = $urandom_range(9, 64);
        5: limit = $urandom_range(1, 65535);
        6: limit = $urandom_range(2, 30);
        default: limit = MAX_PAYLOAD_RESET;
      endcase
      write_limit(16'(limit));
      fill_traffic(HALF_PHASE, limit);
      send_line();
      wait_for_results();
      fill_traffic(HALF_PHASE, limit);
      send_line();
      wait_for_results();
    end

    repeat (RESULT_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
